@@ src/circular_buffer_deque_defines.svh @@
// assertion macros shared by the deque checker
`ifndef CIRCULAR_BUFFER_DEQUE_DEFINES_SVH
`define CIRCULAR_BUFFER_DEQUE_DEFINES_SVH

// property that must hold in the same cycle as its trigger
`define CBD_ASSERT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
		else $error(msg);

// property whose consequence is checked in the cycle after its trigger
`define CBD_ASSERT_NEXT(lbl, clk, rst_n, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

@@ src/cbd_pkg.sv @@
// ----------------------------------------------------------------------------
// cbd_pkg
// shared types and constants of the circular buffer deque
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package cbd_pkg;

	// default configuration
	localparam int SLOTS_DEF      = 16;
	localparam int DATA_WIDTH_DEF = 32;

	// fixed field widths of the item ports
	localparam int MODE_W  = 3;
	localparam int FIELD_W = 32;

	// command codes
	typedef enum logic [MODE_W-1:0] {
		MODE_NONE       = 3'd0,
		MODE_PUSH_BACK  = 3'd1,
		MODE_PUSH_FRONT = 3'd2,
		MODE_POP_FRONT  = 3'd3,
		MODE_POP_BACK   = 3'd4,
		MODE_CLEAR      = 3'd5
	} mode_t;

	// memory port control from sequencer to ring store
	typedef struct packed {
		logic wr_en;
		logic rd_en;
	} ring_ctl_t;

	// sequencer status towards the output register
	typedef struct packed {
		logic ready;
		logic ok;
		logic empty;
	} seq_stat_t;

endpackage

@@ src/cbd_ring.sv @@
// ----------------------------------------------------------------------------
// cbd_ring
// ring store: one write port, two registered read ports
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbd_ring #(
	parameter int SLOTS      = cbd_pkg::SLOTS_DEF,
	parameter int DATA_WIDTH = cbd_pkg::DATA_WIDTH_DEF,
	localparam int IW        = $clog2(SLOTS)
) (
	input  logic                  clk,
	input  cbd_pkg::ring_ctl_t    ctl,
	input  logic [IW-1:0]         wr_addr,
	input  logic [DATA_WIDTH-1:0] wr_data,
	input  logic [IW-1:0]         rd_addr_front,
	input  logic [IW-1:0]         rd_addr_back,
	output logic [DATA_WIDTH-1:0] rd_front,
	output logic [DATA_WIDTH-1:0] rd_back
);

	logic [DATA_WIDTH-1:0] ring_q [SLOTS];
	logic [DATA_WIDTH-1:0] rd_front_q;
	logic [DATA_WIDTH-1:0] rd_back_q;

	// write port
	always_ff @(posedge clk) begin
		if (ctl.wr_en) begin
			ring_q[wr_addr] <= wr_data;
		end
	end

	// read ports, data held until the next read
	always_ff @(posedge clk) begin
		if (ctl.rd_en) begin
			rd_front_q <= ring_q[rd_addr_front];
			rd_back_q  <= ring_q[rd_addr_back];
		end
	end

	assign rd_front = rd_front_q;
	assign rd_back  = rd_back_q;

endmodule

@@ src/cbd_ctrl.sv @@
// ----------------------------------------------------------------------------
// cbd_ctrl
// command decode, head and tail indices and the access sequencer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cbd_ctrl #(
	parameter int SLOTS      = cbd_pkg::SLOTS_DEF,
	parameter int DATA_WIDTH = cbd_pkg::DATA_WIDTH_DEF,
	localparam int IW        = $clog2(SLOTS)
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cbd_pkg::MODE_W-1:0]  mode,
	input  logic [cbd_pkg::FIELD_W-1:0] value,
	input  logic                        out_free,
	output cbd_pkg::seq_stat_t          stat,
	output cbd_pkg::ring_ctl_t          ctl,
	output logic [IW-1:0]               wr_addr,
	output logic [DATA_WIDTH-1:0]       wr_data,
	output logic [IW-1:0]               rd_addr_front,
	output logic [IW-1:0]               rd_addr_back
);

	localparam logic [IW-1:0] LAST = IW'(SLOTS - 1);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_READ,
		ST_DATA
	} state_t;

	state_t        state_q;
	logic [IW-1:0] head_q;
	logic [IW-1:0] tail_q;
	logic          ok_q;

	logic          accept;
	logic [IW-1:0] head_up;
	logic [IW-1:0] head_dn;
	logic [IW-1:0] tail_up;
	logic [IW-1:0] tail_dn;
	logic [IW-1:0] head_n;
	logic [IW-1:0] tail_n;
	logic          ok_n;
	logic          wr_en;
	logic          empty;

	assign accept = in_valid && (state_q == ST_IDLE);
	assign empty  = (head_q == tail_q);

	// ring neighbours of both indices
	assign head_up = (head_q == LAST) ? '0 : head_q + 1'b1;
	assign head_dn = (head_q == '0) ? LAST : head_q - 1'b1;
	assign tail_up = (tail_q == LAST) ? '0 : tail_q + 1'b1;
	assign tail_dn = (tail_q == '0) ? LAST : tail_q - 1'b1;

	// command decode
	always_comb begin
		head_n  = head_q;
		tail_n  = tail_q;
		ok_n    = 1'b1;
		wr_en   = 1'b0;
		wr_addr = tail_q;
		case (cbd_pkg::mode_t'(mode))
			cbd_pkg::MODE_PUSH_BACK: begin
				if (tail_up == head_q) begin
					ok_n = 1'b0;
				end else begin
					wr_en  = 1'b1;
					tail_n = tail_up;
				end
			end
			cbd_pkg::MODE_PUSH_FRONT: begin
				wr_addr = head_dn;
				if (head_dn == tail_q) begin
					ok_n = 1'b0;
				end else begin
					wr_en  = 1'b1;
					head_n = head_dn;
				end
			end
			cbd_pkg::MODE_POP_FRONT: begin
				if (empty) begin
					ok_n = 1'b0;
				end else begin
					head_n = head_up;
				end
			end
			cbd_pkg::MODE_POP_BACK: begin
				if (empty) begin
					ok_n = 1'b0;
				end else begin
					tail_n = tail_dn;
				end
			end
			cbd_pkg::MODE_CLEAR: begin
				head_n = '0;
				tail_n = '0;
			end
			default: begin
			end
		endcase
	end

	// state, indices and command status
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			head_q  <= '0;
			tail_q  <= '0;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (accept) begin
						head_q  <= head_n;
						tail_q  <= tail_n;
						ok_q    <= ok_n;
						state_q <= ST_READ;
					end
				end
				ST_READ: begin
					state_q <= ST_DATA;
				end
				ST_DATA: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// memory access, the reads come in the cycle after the write
	assign ctl.wr_en     = accept && wr_en;
	assign ctl.rd_en     = (state_q == ST_READ);
	assign wr_data       = DATA_WIDTH'(value);
	assign rd_addr_front = head_q;
	assign rd_addr_back  = tail_dn;

	assign in_stall   = (state_q != ST_IDLE);
	assign stat.ready = (state_q == ST_DATA);
	assign stat.ok    = ok_q;
	assign stat.empty = empty;

endmodule

@@ src/circular_buffer_deque.sv @@
// ----------------------------------------------------------------------------
// circular_buffer_deque
// double-ended queue of up to SLOTS-1 elements held in a ring store
// ----------------------------------------------------------------------------
// Each item carries one command (none, push back, push front, pop front,
// pop back, clear) and yields one result item with ok, the empty flag and
// the front and back elements after the command, which read zero when the
// queue is empty. The command updates the indices and writes the ring
// store in the cycle it is accepted, the store is read at the new front
// and back in the next one (ST_READ), and the registered read data forms
// the result in ST_DATA once the output register is free. in_stall is high
// in ST_READ and ST_DATA, so a new item is taken only after the result of
// the last one has entered the output register. The output register lets
// the next item enter while a result is still waiting to be taken. No
// clearing pass is needed after reset.
`timescale 1ns / 1ps

module circular_buffer_deque #(
	parameter int SLOTS      = cbd_pkg::SLOTS_DEF,
	parameter int DATA_WIDTH = cbd_pkg::DATA_WIDTH_DEF
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [cbd_pkg::MODE_W-1:0]  mode,
	input  logic [cbd_pkg::FIELD_W-1:0] value,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic                        ok,
	output logic                        empty_res,
	output logic [cbd_pkg::FIELD_W-1:0] front_value,
	output logic [cbd_pkg::FIELD_W-1:0] back_value
);

	localparam int IW = $clog2(SLOTS);

	cbd_pkg::seq_stat_t    stat;
	cbd_pkg::ring_ctl_t    ctl;
	logic [IW-1:0]         wr_addr;
	logic [DATA_WIDTH-1:0] wr_data;
	logic [IW-1:0]         rd_addr_front;
	logic [IW-1:0]         rd_addr_back;
	logic [DATA_WIDTH-1:0] rd_front;
	logic [DATA_WIDTH-1:0] rd_back;

	logic                        out_valid_q;
	logic                        ok_q;
	logic                        empty_q;
	logic [cbd_pkg::FIELD_W-1:0] front_q;
	logic [cbd_pkg::FIELD_W-1:0] back_q;
	logic                        out_free;
	logic                        load;

	cbd_ctrl #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.mode          (mode),
		.value         (value),
		.out_free      (out_free),
		.stat          (stat),
		.ctl           (ctl),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr_front (rd_addr_front),
		.rd_addr_back  (rd_addr_back)
	);

	cbd_ring #(
		.SLOTS      (SLOTS),
		.DATA_WIDTH (DATA_WIDTH)
	) u_ring (
		.clk           (clk),
		.ctl           (ctl),
		.wr_addr       (wr_addr),
		.wr_data       (wr_data),
		.rd_addr_front (rd_addr_front),
		.rd_addr_back  (rd_addr_back),
		.rd_front      (rd_front),
		.rd_back       (rd_back)
	);

	// output register handshake
	assign out_free = !out_valid_q || !out_stall;
	assign load     = stat.ready && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	// result fields, elements zeroed on an empty queue
	always_ff @(posedge clk) begin
		if (load) begin
			ok_q    <= stat.ok;
			empty_q <= stat.empty;
			front_q <= stat.empty ? '0 : cbd_pkg::FIELD_W'(rd_front);
			back_q  <= stat.empty ? '0 : cbd_pkg::FIELD_W'(rd_back);
		end
	end

	assign out_valid   = out_valid_q;
	assign ok          = ok_q;
	assign empty_res   = empty_q;
	assign front_value = front_q;
	assign back_value  = back_q;

endmodule

@@ src/cbd_checker.sv @@
// ----------------------------------------------------------------------------
// cbd_checker
// port-level checks of the deque, bound to the top level
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "circular_buffer_deque_defines.svh"

module cbd_checker (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        in_valid,
	input logic                        in_stall,
	input logic [cbd_pkg::MODE_W-1:0]  mode,
	input logic [cbd_pkg::FIELD_W-1:0] value,
	input logic                        out_valid,
	input logic                        out_stall,
	input logic                        ok,
	input logic                        empty_res,
	input logic [cbd_pkg::FIELD_W-1:0] front_value,
	input logic [cbd_pkg::FIELD_W-1:0] back_value
);

	logic in_acc;

	assign in_acc = in_valid && !in_stall;

	// one item at a time: input closes after an accepted item
	`CBD_ASSERT_NEXT(a_busy_after_accept, clk, arst_n, in_acc, in_stall, "input open after accept")

	// a stalled input item stays offered with the same fields
	`CBD_ASSERT_NEXT(a_in_hold, clk, arst_n, in_valid && in_stall,
		in_valid && $stable(mode) && $stable(value), "input item changed under stall")

	// empty queue reports zero elements
	`CBD_ASSERT(a_empty_zero, clk, arst_n, out_valid && empty_res,
		front_value == '0 && back_value == '0, "nonzero element on empty queue")

	// a stalled result stays offered
	`CBD_ASSERT_NEXT(a_out_hold, clk, arst_n, out_valid && out_stall, out_valid,
		"result dropped under stall")

	// a stalled result keeps its fields
	`CBD_ASSERT_NEXT(a_out_stable, clk, arst_n, out_valid && out_stall,
		$stable(ok) && $stable(empty_res) && $stable(front_value) && $stable(back_value),
		"result changed under stall")

endmodule

bind circular_buffer_deque cbd_checker u_checker (.*);
